// File: src/tpac_pkg.sv
// Shared widths, types and constants for the three-point angle cosine core.
// No dependencies; imported by every module of the block.
package tpac_pkg;

    localparam int COORD_WIDTH = 24;

    // edge vector component, signed, one bit wider than a coordinate
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 2;
    // squared length, unsigned
    localparam int SQ_W    = 2 * COORD_WIDTH + 2;
    // split width for the partial products of the wide squares
    localparam int HALF_W  = COORD_WIDTH + 2;
    localparam int PAIR_W  = 2 * HALF_W;
    localparam int WIDE_W  = 4 * HALF_W;

    // result bits found by the cell chain, one per cell
    localparam int K_W     = 16;
    localparam int CELLS   = K_W;
    localparam int COS_W   = 16;
    localparam int FRAC_SH = 2 * K_W;
    localparam int A_SH    = K_W + 1;

    // residual width: 2^FRAC_SH * |d|^2 plus headroom for the trial terms
    localparam int RES_W   = WIDE_W + FRAC_SH + 4;

    localparam logic [COS_W-1:0] COS_MAX = {1'b0, {(COS_W-1){1'b1}}};
    localparam logic [K_W:0]     K_LIMIT = {2'b01, {(K_W-1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [RES_W-1:0]       res_t;
    typedef logic [K_W-1:0]                k_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic degen;
    } ctl_t;

endpackage

// File: src/tpac_front.sv
// Front pipeline: edge vectors, dot product, squared lengths, wide squares
// and the initial residual for the cell chain. Depends on tpac_pkg.
module tpac_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  tpac_pkg::coord_t      point_a_x,
    input  tpac_pkg::coord_t      point_a_y,
    input  tpac_pkg::coord_t      point_a_z,
    input  tpac_pkg::coord_t      vertex_x,
    input  tpac_pkg::coord_t      vertex_y,
    input  tpac_pkg::coord_t      vertex_z,
    input  tpac_pkg::coord_t      point_c_x,
    input  tpac_pkg::coord_t      point_c_y,
    input  tpac_pkg::coord_t      point_c_z,
    output tpac_pkg::ctl_t        ctl,
    output tpac_pkg::res_t        r,
    output tpac_pkg::res_t        a,
    output tpac_pkg::res_t        b
);
    import tpac_pkg::*;

    coord_t ca [3];
    coord_t cb [3];
    coord_t cc [3];

    ctl_t   c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;

    diff_t  p_reg [3];
    diff_t  q_reg [3];
    prod_t  pq_reg [3];
    prod_t  pp_reg [3];
    prod_t  qq_reg [3];
    logic signed [DOT_W-1:0] dot_reg;
    logic [SQ_W-1:0]   lp_reg, lq_reg;
    logic [PAIR_W-1:0] dm_reg, lp4_reg, lq4_reg;
    logic [PAIR_W-1:0] pl0_reg, pl1_reg, pl2_reg, pl3_reg;
    logic [PAIR_W-1:0] d0_reg, d1_reg, d3_reg;
    logic [WIDE_W-1:0] pw_reg, dw_reg;
    res_t   r_reg, a_reg, b_reg;

    logic   pzero, qzero;
    logic signed [DOT_W-1:0] dot_next;
    logic [SQ_W-1:0]   lp_next, lq_next;
    logic [PAIR_W-1:0] dm_next;
    logic [WIDE_W-1:0] pw_next, dw_next;
    res_t   pw_ext, dw_ext;

    assign ca[0] = point_a_x;
    assign ca[1] = point_a_y;
    assign ca[2] = point_a_z;
    assign cb[0] = vertex_x;
    assign cb[1] = vertex_y;
    assign cb[2] = vertex_z;
    assign cc[0] = point_c_x;
    assign cc[1] = point_c_y;
    assign cc[2] = point_c_z;

    assign pzero = (p_reg[0] == '0) && (p_reg[1] == '0) && (p_reg[2] == '0);
    assign qzero = (q_reg[0] == '0) && (q_reg[1] == '0) && (q_reg[2] == '0);

    always_comb
    begin
        dot_next = DOT_W'(pq_reg[0]) + DOT_W'(pq_reg[1]) + DOT_W'(pq_reg[2]);
        lp_next  = SQ_W'($unsigned(pp_reg[0])) + SQ_W'($unsigned(pp_reg[1]))
                 + SQ_W'($unsigned(pp_reg[2]));
        lq_next  = SQ_W'($unsigned(qq_reg[0])) + SQ_W'($unsigned(qq_reg[1]))
                 + SQ_W'($unsigned(qq_reg[2]));
        if (dot_reg[DOT_W-1])
            dm_next = PAIR_W'($unsigned(-dot_reg));
        else
            dm_next = PAIR_W'($unsigned(dot_reg));
        pw_next = WIDE_W'({pl3_reg, pl0_reg})
                + (WIDE_W'(pl1_reg) << HALF_W) + (WIDE_W'(pl2_reg) << HALF_W);
        dw_next = WIDE_W'({d3_reg, d0_reg}) + (WIDE_W'(d1_reg) << (HALF_W + 1));
        pw_ext  = res_t'(pw_reg);
        dw_ext  = res_t'(dw_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
            c7_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= '{valid: in_valid, neg: 1'b0, degen: 1'b0};
            c2_reg <= '{valid: c1_reg.valid, neg: 1'b0, degen: pzero || qzero};
            c3_reg <= c2_reg;
            c4_reg <= '{valid: c3_reg.valid, neg: dot_reg[DOT_W-1],
                        degen: c3_reg.degen};
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
            c7_reg <= c6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]  <= diff_t'(ca[i]) - diff_t'(cb[i]);
                q_reg[i]  <= diff_t'(cc[i]) - diff_t'(cb[i]);
                pq_reg[i] <= p_reg[i] * q_reg[i];
                pp_reg[i] <= p_reg[i] * p_reg[i];
                qq_reg[i] <= q_reg[i] * q_reg[i];
            end
            dot_reg <= dot_next;
            lp_reg  <= lp_next;
            lq_reg  <= lq_next;
            dm_reg  <= dm_next;
            lp4_reg <= PAIR_W'(lp_reg);
            lq4_reg <= PAIR_W'(lq_reg);
            pl0_reg <= lp4_reg[HALF_W-1:0] * lq4_reg[HALF_W-1:0];
            pl1_reg <= lp4_reg[HALF_W-1:0] * lq4_reg[PAIR_W-1:HALF_W];
            pl2_reg <= lp4_reg[PAIR_W-1:HALF_W] * lq4_reg[HALF_W-1:0];
            pl3_reg <= lp4_reg[PAIR_W-1:HALF_W] * lq4_reg[PAIR_W-1:HALF_W];
            d0_reg  <= dm_reg[HALF_W-1:0] * dm_reg[HALF_W-1:0];
            d1_reg  <= dm_reg[HALF_W-1:0] * dm_reg[PAIR_W-1:HALF_W];
            d3_reg  <= dm_reg[PAIR_W-1:HALF_W] * dm_reg[PAIR_W-1:HALF_W];
            pw_reg  <= pw_next;
            dw_reg  <= dw_next;
            // residual for k = 0 (t = -1); trial terms scaled for the top bit
            r_reg   <= (dw_ext <<< FRAC_SH) - pw_ext;
            a_reg   <= -(pw_ext <<< A_SH);
            b_reg   <= pw_ext <<< FRAC_SH;
        end
    end

    assign ctl = c7_reg;
    assign r   = r_reg;
    assign a   = a_reg;
    assign b   = b_reg;

endmodule

// File: src/tpac_cell.sv
// One cell of the search chain: decides one bit of the scaled cosine by a
// trial subtract of the residual, then rescales for the next bit. Uses tpac_pkg.
module tpac_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  tpac_pkg::ctl_t    ctl_in,
    input  tpac_pkg::res_t    r_in,
    input  tpac_pkg::res_t    a_in,
    input  tpac_pkg::res_t    b_in,
    input  tpac_pkg::k_t      k_in,
    output tpac_pkg::ctl_t    ctl_out,
    output tpac_pkg::res_t    r_out,
    output tpac_pkg::res_t    a_out,
    output tpac_pkg::res_t    b_out,
    output tpac_pkg::k_t      k_out
);
    import tpac_pkg::*;

    ctl_t ctl_reg;
    res_t r_reg, a_reg, b_reg;
    k_t   k_reg;
    res_t trial;
    logic take;
    res_t r_next, a_next;

    // (t + 2^(j+1))^2 P - t^2 P = a + b, with a = 2^(j+2) t P, b = 2^(2j+2) P
    always_comb
    begin
        trial  = r_in - a_in - b_in;
        take   = !trial[RES_W-1];
        r_next = take ? trial : r_in;
        a_next = take ? a_in + (b_in <<< 1) : a_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            a_reg <= a_next >>> 1;
            b_reg <= b_in >>> 2;
            k_reg <= {k_in[K_W-2:0], take};
        end
    end

    assign ctl_out = ctl_reg;
    assign r_out   = r_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign k_out   = k_reg;

endmodule

// File: src/three_point_angle_cosine_core.sv
// Three-point angle cosine core: cosine of the angle at a vertex in Q1.15.
// Depends on tpac_pkg, tpac_front and tpac_cell.
//
// Input channel: in_valid / in_stall carry one triple of Q12.12 points
// (A, vertex B, C) per transaction. Output channel: out_valid / out_stall
// carry cosine (signed Q1.15, rounded to nearest, +1 saturated to 32767)
// and degenerate, which is set with cosine 0 when A or C equals B.
// One transaction is taken every cycle while the output is not stalled.
// The pipeline has 7 front stages (differences, products, sums, magnitude,
// split partial products of the wide squares, their sums, residual setup),
// 16 chain cells that each settle one result bit, and the output register.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped.
// Reset clears all valid bits; no results are pending after it.
module three_point_angle_cosine_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tpac_pkg::coord_t      point_a_x,
    input  tpac_pkg::coord_t      point_a_y,
    input  tpac_pkg::coord_t      point_a_z,
    input  tpac_pkg::coord_t      vertex_x,
    input  tpac_pkg::coord_t      vertex_y,
    input  tpac_pkg::coord_t      vertex_z,
    input  tpac_pkg::coord_t      point_c_x,
    input  tpac_pkg::coord_t      point_c_y,
    input  tpac_pkg::coord_t      point_c_z,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    cosine,
    output logic                  degenerate
);
    import tpac_pkg::*;

    logic advance;
    ctl_t ctl_c [CELLS+1];
    res_t r_c   [CELLS+1];
    res_t a_c   [CELLS+1];
    res_t b_c   [CELLS+1];
    k_t   k_c   [CELLS+1];

    logic             out_valid_reg;
    logic [COS_W-1:0] cosine_reg, cosine_next;
    logic             degen_reg;
    ctl_t             last;
    k_t               k_last;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    tpac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid),
        .point_a_x (point_a_x),
        .point_a_y (point_a_y),
        .point_a_z (point_a_z),
        .vertex_x  (vertex_x),
        .vertex_y  (vertex_y),
        .vertex_z  (vertex_z),
        .point_c_x (point_c_x),
        .point_c_y (point_c_y),
        .point_c_z (point_c_z),
        .ctl       (ctl_c[0]),
        .r         (r_c[0]),
        .a         (a_c[0]),
        .b         (b_c[0])
    );

    assign k_c[0] = '0;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        tpac_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .ctl_in  (ctl_c[i]),
            .r_in    (r_c[i]),
            .a_in    (a_c[i]),
            .b_in    (b_c[i]),
            .k_in    (k_c[i]),
            .ctl_out (ctl_c[i+1]),
            .r_out   (r_c[i+1]),
            .a_out   (a_c[i+1]),
            .b_out   (b_c[i+1]),
            .k_out   (k_c[i+1])
        );
    end

    assign last   = ctl_c[CELLS];
    assign k_last = k_c[CELLS];

    always_comb
    begin
        if (last.degen)
            cosine_next = '0;
        else if (last.neg)
            cosine_next = COS_W'(-k_last);
        else if (k_last[K_W-1])
            cosine_next = COS_MAX;   // exactly +1
        else
            cosine_next = COS_W'(k_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cosine_reg <= cosine_next;
            degen_reg  <= last.degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cosine     = $signed(cosine_reg);
    assign degenerate = degen_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> cosine == '0)
        else $error("degenerate transaction with nonzero cosine");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid && !last.degen |-> {1'b0, k_last} <= K_LIMIT)
        else $error("cell chain result above unity");

endmodule
